// File: sv/rhdb_pkg.sv
// ----------------------------------------------------------------------------
// rhdb_pkg
// Shared widths, register indexes and types of the 2x2 RGB downscaler.
// ----------------------------------------------------------------------------
package rhdb_pkg;

   localparam int CH_W       = 8;   // one color channel
   localparam int PSUM_W     = 9;   // sum of two channel values
   localparam int SUM_W      = 10;  // sum of four channel values
   localparam int IMG_W_W    = 12;  // frame width register
   localparam int IMG_H_W    = 13;  // frame height register
   localparam int ROW_W      = 12;  // input row counter
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   localparam int WIDTH_RESET  = 640;
   localparam int HEIGHT_RESET = 480;
   localparam int HEIGHT_LIMIT = 4096;
   localparam int MIN_DIM      = 2;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = CSR_IDX_W'(1);

   typedef struct packed {
      logic [PSUM_W-1:0] red;
      logic [PSUM_W-1:0] green;
      logic [PSUM_W-1:0] blue;
   } psum_type;

   // One completed horizontal pair on an odd row, handed to the output stage.
   typedef struct packed {
      logic     valid;
      psum_type sum;
      logic     row_end;
   } issue_type;

endpackage

// File: sv/rhdb_channels.sv
// ----------------------------------------------------------------------------
// rhdb channels
// Valid/ready interfaces for pixel requests, results and register writes.
// ----------------------------------------------------------------------------
interface rhdb_req_if;
   import rhdb_pkg::*;
   logic            valid;
   logic            ready;
   logic [CH_W-1:0] in_red;
   logic [CH_W-1:0] in_green;
   logic [CH_W-1:0] in_blue;
   modport source (output valid, in_red, in_green, in_blue, input ready);
   modport sink (input valid, in_red, in_green, in_blue, output ready);
endinterface

interface rhdb_rsp_if;
   import rhdb_pkg::*;
   logic            valid;
   logic            ready;
   logic [CH_W-1:0] out_red;
   logic [CH_W-1:0] out_green;
   logic [CH_W-1:0] out_blue;
   logic            row_end;
   modport source (output valid, out_red, out_green, out_blue, row_end, input ready);
   modport sink (input valid, out_red, out_green, out_blue, row_end, output ready);
endinterface

interface rhdb_csr_if;
   import rhdb_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: sv/rhdb_line_mem.sv
// ----------------------------------------------------------------------------
// rhdb_line_mem
// Single-port line buffer of pair sums with a registered read.
// ----------------------------------------------------------------------------
module rhdb_line_mem #(
   parameter int DEPTH = 1024
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic                            rd_en,
   input  logic [$clog2(DEPTH)-1:0]        addr,
   input  rhdb_pkg::psum_type              wr_data,
   output rhdb_pkg::psum_type              rd_data
);
   import rhdb_pkg::*;

   psum_type mem_ff [DEPTH];
   psum_type rd_data_ff;

   // Read data holds until the next read, so a stalled consumer keeps it.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/rhdb_front.sv
// ----------------------------------------------------------------------------
// rhdb_front
// Frame registers, column/row counters and horizontal pair summing.
// ----------------------------------------------------------------------------
module rhdb_front #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 pix_accept,
   input  logic [rhdb_pkg::CH_W-1:0]            in_red,
   input  logic [rhdb_pkg::CH_W-1:0]            in_green,
   input  logic [rhdb_pkg::CH_W-1:0]            in_blue,
   input  logic                                 csr_write,
   input  logic [rhdb_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rhdb_pkg::CSR_DATA_W-1:0]      csr_data,
   output logic                                 mem_wr_en,
   output logic                                 mem_rd_en,
   output logic [$clog2(MAX_WIDTH/2)-1:0]       mem_addr,
   output rhdb_pkg::psum_type                   mem_wr_data,
   output rhdb_pkg::issue_type                  issue
);
   import rhdb_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int EW_W  = $clog2(MAX_WIDTH + 1);
   localparam int IDX_W = $clog2(MAX_WIDTH / 2);
   localparam int WIDTH_INIT = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

   logic [EW_W-1:0]    eff_w_ff, eff_w_in;
   logic [IMG_H_W-1:0] eff_h_ff, eff_h_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [CH_W-1:0]    left_r_ff, left_g_ff, left_b_ff;
   logic [31:0]        w_req;
   logic [IMG_H_W-1:0] h_req;
   logic               restart;
   logic               last_col;
   logic               last_row;
   logic               pair_done;

   assign w_req = 32'(csr_data[IMG_W_W-1:0]);
   assign h_req = csr_data[IMG_H_W-1:0];

   // Register writes are clamped once here, so the counters see legal sizes.
   always_comb begin
      eff_w_in = eff_w_ff;
      eff_h_in = eff_h_ff;
      restart  = 1'b0;
      if (csr_write) begin
         unique case (csr_index)
            REG_FRAME_WIDTH: begin
               restart = 1'b1;
               if (w_req < 32'(MIN_DIM)) begin
                  eff_w_in = EW_W'(MIN_DIM);
               end else if (w_req > 32'(MAX_WIDTH)) begin
                  eff_w_in = EW_W'(MAX_WIDTH);
               end else begin
                  eff_w_in = EW_W'(w_req);
               end
            end
            REG_FRAME_HEIGHT: begin
               restart = 1'b1;
               if (h_req < IMG_H_W'(MIN_DIM)) begin
                  eff_h_in = IMG_H_W'(MIN_DIM);
               end else if (h_req > IMG_H_W'(HEIGHT_LIMIT)) begin
                  eff_h_in = IMG_H_W'(HEIGHT_LIMIT);
               end else begin
                  eff_h_in = h_req;
               end
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   assign last_col = (EW_W'(col_ff) == eff_w_ff - EW_W'(1));
   assign last_row = (IMG_H_W'(row_ff) == eff_h_ff - IMG_H_W'(1));

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (pix_accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_w_ff  <= EW_W'(WIDTH_INIT);
         eff_h_ff  <= IMG_H_W'(HEIGHT_RESET);
         col_ff    <= '0;
         row_ff    <= '0;
         left_r_ff <= '0;
         left_g_ff <= '0;
         left_b_ff <= '0;
      end else begin
         eff_w_ff <= eff_w_in;
         eff_h_ff <= eff_h_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         if (pix_accept && !col_ff[0]) begin
            left_r_ff <= in_red;
            left_g_ff <= in_green;
            left_b_ff <= in_blue;
         end
      end
   end

   assign pair_done = pix_accept && col_ff[0];

   assign mem_wr_data.red   = PSUM_W'(left_r_ff) + PSUM_W'(in_red);
   assign mem_wr_data.green = PSUM_W'(left_g_ff) + PSUM_W'(in_green);
   assign mem_wr_data.blue  = PSUM_W'(left_b_ff) + PSUM_W'(in_blue);

   // Even rows store the pair sum; odd rows fetch the one from the row above.
   assign mem_wr_en = pair_done && !row_ff[0];
   assign mem_rd_en = pair_done && row_ff[0];
   assign mem_addr  = IDX_W'(col_ff >> 1);

   assign issue.valid   = mem_rd_en;
   assign issue.sum     = mem_wr_data;
   assign issue.row_end = (EW_W'(col_ff >> 1) == (eff_w_ff >> 1) - EW_W'(1));

endmodule

// File: sv/rhdb_out_stage.sv
// ----------------------------------------------------------------------------
// rhdb_out_stage
// Joins the buffered pair sum with the current one and holds the result.
// ----------------------------------------------------------------------------
module rhdb_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  rhdb_pkg::issue_type  issue,
   input  rhdb_pkg::psum_type   rd_data,
   rhdb_rsp_if.source           rsp,
   output logic                 can_take
);
   import rhdb_pkg::*;

   logic             s1_valid_ff, s1_valid_in;
   psum_type         s1_sum_ff;
   logic             s1_row_end_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CH_W-1:0]  red_ff, green_ff, blue_ff;
   logic             row_end_ff;
   logic             s1_move;
   logic [SUM_W-1:0] tot_r, tot_g, tot_b;

   assign s1_move  = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign can_take = !s1_valid_ff || !rsp_valid_ff || rsp.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (issue.valid) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign tot_r = SUM_W'(rd_data.red) + SUM_W'(s1_sum_ff.red);
   assign tot_g = SUM_W'(rd_data.green) + SUM_W'(s1_sum_ff.green);
   assign tot_b = SUM_W'(rd_data.blue) + SUM_W'(s1_sum_ff.blue);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue.valid) begin
         s1_sum_ff     <= issue.sum;
         s1_row_end_ff <= issue.row_end;
      end
      if (s1_move) begin
         red_ff     <= tot_r[SUM_W-1:2];
         green_ff   <= tot_g[SUM_W-1:2];
         blue_ff    <= tot_b[SUM_W-1:2];
         row_end_ff <= s1_row_end_ff;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.out_red   = red_ff;
   assign rsp.out_green = green_ff;
   assign rsp.out_blue  = blue_ff;
   assign rsp.row_end   = row_end_ff;

endmodule

// File: sv/rgb_half_downscale_box_unit.sv
// ----------------------------------------------------------------------------
// rgb_half_downscale_box_unit
// 2x2 box-filter downscaler for RGB24 frames in raster order.
// ----------------------------------------------------------------------------
// Pixels enter on the req_if channel one request at a time, in raster order.
// Every pixel is consumed; a result leaves on rsp_if only for the second
// pixel of a horizontal pair on an odd input row, carrying the truncated
// average of the 2x2 block and row_end on the last block of an output row.
// An odd last column or an odd last row is consumed without a result.
// The csr_if channel writes the frame width (index 0) and the frame height
// (index 1); it is always ready, and any write to a listed register restarts
// the frame. Writes are expected only while the block is idle.
// Throughput is one pixel per cycle while rsp_if does not stall. A result on
// rsp_if follows the pixel that completes its block, once its sums have passed
// the line buffer read register and then the output register.
// The line buffer is a single-port memory of MAX_WIDTH/2 entries; even rows
// write pair sums into it and odd rows read them back, so the two never
// meet in the same cycle. There is no clearing pass: reset returns the
// counters and registers to their defaults and the block is ready at once.
// When the receiver stalls, the finished result waits in the output register
// and one more result can wait behind it; req_if.ready drops only once both
// are occupied and rsp_if.ready is low.
// ----------------------------------------------------------------------------
module rgb_half_downscale_box_unit #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic        clock,
   input  logic        reset,
   rhdb_req_if.sink    req_if,
   rhdb_rsp_if.source  rsp_if,
   rhdb_csr_if.sink    csr_if
);
   import rhdb_pkg::*;

   localparam int LINE_DEPTH = MAX_WIDTH / 2;
   localparam int IDX_W      = $clog2(LINE_DEPTH);

   logic             pix_accept;
   logic             csr_write;
   logic             mem_wr_en;
   logic             mem_rd_en;
   logic [IDX_W-1:0] mem_addr;
   psum_type         mem_wr_data;
   psum_type         mem_rd_data;
   issue_type        issue;
   logic             can_take;

   // Register writes are never back-pressured.
   assign csr_if.ready = 1'b1;
   assign csr_write    = csr_if.valid;

   assign req_if.ready = can_take;
   assign pix_accept   = req_if.valid && can_take;

   rhdb_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .pix_accept  (pix_accept),
      .in_red      (req_if.in_red),
      .in_green    (req_if.in_green),
      .in_blue     (req_if.in_blue),
      .csr_write   (csr_write),
      .csr_index   (csr_if.index),
      .csr_data    (csr_if.data),
      .mem_wr_en   (mem_wr_en),
      .mem_rd_en   (mem_rd_en),
      .mem_addr    (mem_addr),
      .mem_wr_data (mem_wr_data),
      .issue       (issue)
   );

   rhdb_line_mem #(
      .DEPTH (LINE_DEPTH)
   ) u_line_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .rd_en   (mem_rd_en),
      .addr    (mem_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   rhdb_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .issue    (issue),
      .rd_data  (mem_rd_data),
      .rsp      (rsp_if),
      .can_take (can_take)
   );

endmodule

// File: sv/rhdb_checker.sv
// ----------------------------------------------------------------------------
// rhdb_checker
// Port-level checks of the downscaler, bound to the top level.
// ----------------------------------------------------------------------------
module rhdb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [24:0] rsp_payload
);

   // A stalled result keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Each new result is checked against an earlier accepted request.
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without a matching request");

   // Requests are refused only while a result is stalled at the output.
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request refused without back-pressure");

endmodule

bind rgb_half_downscale_box_unit rhdb_checker u_rhdb_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_payload ({rsp_if.out_red, rsp_if.out_green, rsp_if.out_blue, rsp_if.row_end})
);
